// ----- rtl/core/hpvt_pkg.sv -----
// Shared types, constants and helper functions for the homogeneous point/vector
// transform core. It has no dependencies; the other files refer to it by scoped names.
package hpvt_pkg;

  localparam int NumRegs    = 8;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 64;
  localparam int CoordW     = 32;
  localparam int ProdW      = 2 * CoordW;
  localparam int SumW       = ProdW + 2;
  localparam int FracW      = 16;
  localparam int DW         = SumW - FracW;
  localparam int DivSteps   = 33;
  localparam int DivLatency = DivSteps + 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [DW-1:0]     dval_t;
  typedef logic [CfgDataW-1:0]      cfg_reg_t;

  typedef enum logic {
    FuncPoint  = 1'b0,
    FuncVector = 1'b1
  } func_e;

  localparam dval_t OneQ16 = dval_t'(65536);
  localparam coord_t SatMax = 32'sh7FFF_FFFF;
  localparam coord_t SatMin = 32'sh8000_0000;

  localparam cfg_reg_t RegReset [NumRegs] = '{
    64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  // Even columns live in the upper half of a register, odd columns in the lower.
  function automatic coord_t coef_sel(cfg_reg_t pair, logic odd);
    coef_sel = odd ? coord_t'(pair[31:0]) : coord_t'(pair[63:32]);
  endfunction

  function automatic prod_t mul(coord_t a, coord_t b);
    prod_t ae;
    prod_t be;
    ae = prod_t'(a);
    be = prod_t'(b);
    mul = ae * be;
  endfunction

  function automatic coord_t sat32(dval_t d);
    if (d > dval_t'(SatMax)) begin
      sat32 = SatMax;
    end else if (d < dval_t'(SatMin)) begin
      sat32 = SatMin;
    end else begin
      sat32 = coord_t'(d);
    end
  endfunction

endpackage

// ----- rtl/core/hpvt_div_pipe.sv -----
// Pipelined signed Q16.16 divider for one coordinate, one quotient bit per stage.
// Depends on hpvt_pkg for widths, the step count and the saturation limits.
module hpvt_div_pipe (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  hpvt_pkg::dval_t      num_i,
  input  hpvt_pkg::dval_t      den_i,
  output hpvt_pkg::coord_t     res_o
);

  localparam int DW = hpvt_pkg::DW;
  localparam int QW = hpvt_pkg::DivSteps;

  logic [DW-1:0] na_q, da_q;
  logic          nega_q;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] nq_q  [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic          ovf_q [QW+1];
  logic          neg_q [QW+1];

  hpvt_pkg::coord_t res_q;

  // Magnitudes and result sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      na_q   <= num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
      da_q   <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      nega_q <= num_i[DW-1] ^ den_i[DW-1];
    end
  end

  // Integer part must stay below 2^16, otherwise the result saturates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= {16'b0, na_q} >= {da_q, 16'b0};
      rem_q[0] <= DW'(na_q[DW-1:16]);
      nq_q[0]  <= {na_q[15:0], 17'b0};
      d_q[0]   <= da_q;
      neg_q[0] <= nega_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0]   trial;
    logic          take;
    logic [DW:0]   diff;
    assign trial = {rem_q[k], nq_q[k][QW-1]};
    assign take  = trial >= {1'b0, d_q[k]};
    assign diff  = trial - {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[k+1]  <= {nq_q[k][QW-2:0], take};
        d_q[k+1]   <= d_q[k];
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  // Round half away from zero on the magnitude, then apply sign and saturate.
  logic [QW:0]   rsum;
  logic [QW-1:0] mag;
  always_comb begin
    rsum = {1'b0, nq_q[QW]} + (QW+1)'(1);
    mag  = rsum[QW:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (ovf_q[QW]) begin
        res_q <= neg_q[QW] ? hpvt_pkg::SatMin : hpvt_pkg::SatMax;
      end else if (neg_q[QW]) begin
        res_q <= (mag >= QW'(33'h0_8000_0000)) ? hpvt_pkg::SatMin
                                               : hpvt_pkg::coord_t'(-mag[31:0]);
      end else begin
        res_q <= (mag > QW'(33'h0_7FFF_FFFF)) ? hpvt_pkg::SatMax
                                              : hpvt_pkg::coord_t'(mag[31:0]);
      end
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/core/homogeneous_point_vector_transform_core.sv -----
// Top level of the homogeneous 4x4 point/vector transform core.
// Depends on hpvt_pkg and instantiates hpvt_div_pipe once per coordinate.
//
// Usage:
// The input channel (in_valid_i/in_ready_o) carries one beat per item: func_i
// selects point mode (full 4x4 product, divide by w unless w is exactly one) or
// vector mode (upper 3x3 only). The output channel (out_valid_o/out_ready_i)
// returns one beat per item in order, with w_zero_o set when a point's w
// rounds to zero. The eight 64-bit matrix registers are written through the
// cfg channel; cfg_ready_o is always high and indexes beyond seven are dropped.
// Write the matrix only while no items are in flight.
//
// An accepted beat passes one stage of multipliers, one stage of row sums with
// rounding, then the divider, whose 33 restoring steps (one quotient bit per
// stage) dominate the depth, before its result reaches the output register.
// Throughput is one beat per cycle while the output register is not stalled.
// All stages advance together while the output register is empty or being
// taken, so a new beat is taken in the same cycle a waiting result leaves.
// When the receiver stalls, the whole pipeline holds and nothing is lost.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_vector_transform_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  hpvt_pkg::coord_t                  in_x_i,
  input  hpvt_pkg::coord_t                  in_y_i,
  input  hpvt_pkg::coord_t                  in_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hpvt_pkg::coord_t                  out_x_o,
  output hpvt_pkg::coord_t                  out_y_o,
  output hpvt_pkg::coord_t                  out_z_o,
  output logic                              w_zero_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hpvt_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  hpvt_pkg::cfg_reg_t                cfg_data_i
);

  localparam int L = hpvt_pkg::DivLatency;

  typedef struct packed {
    logic             valid;
    logic             use_alt;
    logic             w_zero;
    hpvt_pkg::coord_t alt_x;
    hpvt_pkg::coord_t alt_y;
    hpvt_pkg::coord_t alt_z;
  } side_t;

  // Matrix registers.
  hpvt_pkg::cfg_reg_t cfg_q [hpvt_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hpvt_pkg::NumRegs; i++) begin
        cfg_q[i] <= hpvt_pkg::RegReset[i];
      end
    end else if (cfg_valid_i && (cfg_index_i < hpvt_pkg::CfgIdxW'(hpvt_pkg::NumRegs))) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Global advance: the output register is free or is being emptied.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: twelve products, registered.
  hpvt_pkg::coord_t v [3];
  hpvt_pkg::prod_t  prod_d [4][3];
  hpvt_pkg::prod_t  prod_q [4][3];
  logic             p1_valid_q;
  hpvt_pkg::func_e  p1_func_q;

  always_comb begin
    v[0] = in_x_i;
    v[1] = in_y_i;
    v[2] = in_z_i;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = hpvt_pkg::mul(
          hpvt_pkg::coef_sel(cfg_q[2*r + c/2], c[0]), v[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= prod_d;
      p1_func_q <= hpvt_pkg::func_e'(func_i);
    end
  end

  // Stage 2: exact row sums plus translation in point mode, rounded to Q34.16.
  hpvt_pkg::dval_t d_d [4];
  hpvt_pkg::dval_t d_q [4];
  logic            p2_valid_q;
  hpvt_pkg::func_e p2_func_q;

  always_comb begin
    hpvt_pkg::sum_t s;
    hpvt_pkg::sum_t t;
    for (int r = 0; r < 4; r++) begin
      t = hpvt_pkg::sum_t'(hpvt_pkg::coef_sel(cfg_q[2*r + 1], 1'b1)) <<< 16;
      s = hpvt_pkg::sum_t'(prod_q[r][0]) + hpvt_pkg::sum_t'(prod_q[r][1])
        + hpvt_pkg::sum_t'(prod_q[r][2]) + hpvt_pkg::sum_t'(32768);
      if (p1_func_q == hpvt_pkg::FuncPoint) begin
        s = s + t;
      end
      d_d[r] = s[hpvt_pkg::SumW-1:hpvt_pkg::FracW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (en) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q       <= d_d;
      p2_func_q <= p1_func_q;
    end
  end

  // Cases that bypass the divider: vector mode, w exactly one, w zero.
  side_t side_d;
  always_comb begin
    logic is_vec;
    logic w_one;
    logic w_nil;
    hpvt_pkg::coord_t alt [3];
    is_vec = (p2_func_q == hpvt_pkg::FuncVector);
    w_one  = (d_q[3] == hpvt_pkg::OneQ16);
    w_nil  = (d_q[3] == '0);
    for (int c = 0; c < 3; c++) begin
      if (!is_vec && w_nil) begin
        if (d_q[c] == '0) begin
          alt[c] = '0;
        end else begin
          alt[c] = d_q[c][hpvt_pkg::DW-1] ? hpvt_pkg::SatMin : hpvt_pkg::SatMax;
        end
      end else begin
        alt[c] = hpvt_pkg::sat32(d_q[c]);
      end
    end
    side_d.valid   = p2_valid_q;
    side_d.use_alt = is_vec || w_one || w_nil;
    side_d.w_zero  = !is_vec && w_nil;
    side_d.alt_x   = alt[0];
    side_d.alt_y   = alt[1];
    side_d.alt_z   = alt[2];
  end

  // Delay line that keeps the side data aligned with the divider outputs.
  side_t side_q [L];
  for (genvar k = 0; k < L; k++) begin : g_line
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en) begin
        side_q[k] <= (k == 0) ? side_d : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  hpvt_pkg::coord_t div_res [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    hpvt_div_pipe u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (d_q[c]),
      .den_i (d_q[3]),
      .res_o (div_res[c])
    );
  end

  // Output register.
  hpvt_pkg::coord_t out_x_q, out_y_q, out_z_q;
  logic             w_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_q[L-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q  <= side_q[L-1].use_alt ? side_q[L-1].alt_x : div_res[0];
      out_y_q  <= side_q[L-1].use_alt ? side_q[L-1].alt_y : div_res[1];
      out_z_q  <= side_q[L-1].use_alt ? side_q[L-1].alt_z : div_res[2];
      w_zero_q <= side_q[L-1].w_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign w_zero_o    = w_zero_q;

  // A flagged point always carries a fully saturated or zero x coordinate.
  a_wzero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && w_zero_o |->
      (out_x_o == hpvt_pkg::SatMax || out_x_o == hpvt_pkg::SatMin || out_x_o == '0))
    else $error("w_zero result with unsaturated x");

  // An accepted beat always enters the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> p1_valid_q)
    else $error("accepted beat lost at stage one");

  // A stalled result keeps the last delay-line slot and the stage-two valid bit frozen.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(side_q[L-1]) && $stable(p2_valid_q))
    else $error("pipeline moved during stall");

endmodule
